@@ rtl/core/s512bh_pkg.sv @@
// Shared types, constants and round functions for the SHA-512/256 block hash.
package s512bh_pkg;

	localparam int WORD_W = 64;
	localparam int BLOCK_WORDS = 16;
	localparam int ROUNDS = 80;
	localparam int RND_W = $clog2(ROUNDS);
	localparam int CNT_W = $clog2(BLOCK_WORDS);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [7:0][WORD_W-1:0] word8_t;
	typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] window_t;
	typedef logic [RND_W-1:0] rnd_t;

	typedef struct packed {
		logic load;
		logic step;
	} sched_ctrl_t;

	typedef struct packed {
		logic init;
		logic step;
	} round_ctrl_t;

	localparam word8_t INIT_VECTOR = {
		64'h0EB72DDC81C52CA2, 64'h2B0199FC2C85B8AA,
		64'hBE5E1E2553863992, 64'h96283EE2A88EFFE3,
		64'h963877195940EABD, 64'h2393B86B6F53B151,
		64'h9F555FA3C84C64C2, 64'h22312194FC2BF72C
	};

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic word_t round_k(input rnd_t t);
		case (t)
			7'd0: round_k = 64'h428A2F98D728AE22;
			7'd1: round_k = 64'h7137449123EF65CD;
			7'd2: round_k = 64'hB5C0FBCFEC4D3B2F;
			7'd3: round_k = 64'hE9B5DBA58189DBBC;
			7'd4: round_k = 64'h3956C25BF348B538;
			7'd5: round_k = 64'h59F111F1B605D019;
			7'd6: round_k = 64'h923F82A4AF194F9B;
			7'd7: round_k = 64'hAB1C5ED5DA6D8118;
			7'd8: round_k = 64'hD807AA98A3030242;
			7'd9: round_k = 64'h12835B0145706FBE;
			7'd10: round_k = 64'h243185BE4EE4B28C;
			7'd11: round_k = 64'h550C7DC3D5FFB4E2;
			7'd12: round_k = 64'h72BE5D74F27B896F;
			7'd13: round_k = 64'h80DEB1FE3B1696B1;
			7'd14: round_k = 64'h9BDC06A725C71235;
			7'd15: round_k = 64'hC19BF174CF692694;
			7'd16: round_k = 64'hE49B69C19EF14AD2;
			7'd17: round_k = 64'hEFBE4786384F25E3;
			7'd18: round_k = 64'h0FC19DC68B8CD5B5;
			7'd19: round_k = 64'h240CA1CC77AC9C65;
			7'd20: round_k = 64'h2DE92C6F592B0275;
			7'd21: round_k = 64'h4A7484AA6EA6E483;
			7'd22: round_k = 64'h5CB0A9DCBD41FBD4;
			7'd23: round_k = 64'h76F988DA831153B5;
			7'd24: round_k = 64'h983E5152EE66DFAB;
			7'd25: round_k = 64'hA831C66D2DB43210;
			7'd26: round_k = 64'hB00327C898FB213F;
			7'd27: round_k = 64'hBF597FC7BEEF0EE4;
			7'd28: round_k = 64'hC6E00BF33DA88FC2;
			7'd29: round_k = 64'hD5A79147930AA725;
			7'd30: round_k = 64'h06CA6351E003826F;
			7'd31: round_k = 64'h142929670A0E6E70;
			7'd32: round_k = 64'h27B70A8546D22FFC;
			7'd33: round_k = 64'h2E1B21385C26C926;
			7'd34: round_k = 64'h4D2C6DFC5AC42AED;
			7'd35: round_k = 64'h53380D139D95B3DF;
			7'd36: round_k = 64'h650A73548BAF63DE;
			7'd37: round_k = 64'h766A0ABB3C77B2A8;
			7'd38: round_k = 64'h81C2C92E47EDAEE6;
			7'd39: round_k = 64'h92722C851482353B;
			7'd40: round_k = 64'hA2BFE8A14CF10364;
			7'd41: round_k = 64'hA81A664BBC423001;
			7'd42: round_k = 64'hC24B8B70D0F89791;
			7'd43: round_k = 64'hC76C51A30654BE30;
			7'd44: round_k = 64'hD192E819D6EF5218;
			7'd45: round_k = 64'hD69906245565A910;
			7'd46: round_k = 64'hF40E35855771202A;
			7'd47: round_k = 64'h106AA07032BBD1B8;
			7'd48: round_k = 64'h19A4C116B8D2D0C8;
			7'd49: round_k = 64'h1E376C085141AB53;
			7'd50: round_k = 64'h2748774CDF8EEB99;
			7'd51: round_k = 64'h34B0BCB5E19B48A8;
			7'd52: round_k = 64'h391C0CB3C5C95A63;
			7'd53: round_k = 64'h4ED8AA4AE3418ACB;
			7'd54: round_k = 64'h5B9CCA4F7763E373;
			7'd55: round_k = 64'h682E6FF3D6B2B8A3;
			7'd56: round_k = 64'h748F82EE5DEFB2FC;
			7'd57: round_k = 64'h78A5636F43172F60;
			7'd58: round_k = 64'h84C87814A1F0AB72;
			7'd59: round_k = 64'h8CC702081A6439EC;
			7'd60: round_k = 64'h90BEFFFA23631E28;
			7'd61: round_k = 64'hA4506CEBDE82BDE9;
			7'd62: round_k = 64'hBEF9A3F7B2C67915;
			7'd63: round_k = 64'hC67178F2E372532B;
			7'd64: round_k = 64'hCA273ECEEA26619C;
			7'd65: round_k = 64'hD186B8C721C0C207;
			7'd66: round_k = 64'hEADA7DD6CDE0EB1E;
			7'd67: round_k = 64'hF57D4F7FEE6ED178;
			7'd68: round_k = 64'h06F067AA72176FBA;
			7'd69: round_k = 64'h0A637DC5A2C898A6;
			7'd70: round_k = 64'h113F9804BEF90DAE;
			7'd71: round_k = 64'h1B710B35131C471B;
			7'd72: round_k = 64'h28DB77F523047D84;
			7'd73: round_k = 64'h32CAAB7B40C72493;
			7'd74: round_k = 64'h3C9EBE0A15C9BEBC;
			7'd75: round_k = 64'h431D67C49C100D4C;
			7'd76: round_k = 64'h4CC5D4BECB3E42B6;
			7'd77: round_k = 64'h597F299CFC657E2A;
			7'd78: round_k = 64'h5FCB6FAB3AD6FAEC;
			7'd79: round_k = 64'h6C44198C4A475817;
			default: round_k = '0;
		endcase
	endfunction

endpackage

@@ rtl/core/s512bh_sched.sv @@
// Message schedule: sixteen-word shift window with on-the-fly expansion.
module s512bh_sched (
	input  logic                      clk,
	input  s512bh_pkg::sched_ctrl_t   ctrl,
	input  s512bh_pkg::word_t         word_in,
	output s512bh_pkg::word_t         wt
);
	import s512bh_pkg::*;

	window_t w_q;
	word_t   w_next;

	assign w_next = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	assign wt = w_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			w_q <= {word_in, w_q[BLOCK_WORDS-1:1]};
		end else if (ctrl.step) begin
			w_q <= {w_next, w_q[BLOCK_WORDS-1:1]};
		end
	end

endmodule

@@ rtl/core/s512bh_round.sv @@
// Compression round unit: eight working registers, one round per step.
module s512bh_round (
	input  logic                      clk,
	input  s512bh_pkg::round_ctrl_t   ctrl,
	input  s512bh_pkg::word8_t        init_val,
	input  s512bh_pkg::word_t         kt,
	input  s512bh_pkg::word_t         wt,
	output s512bh_pkg::word8_t        work
);
	import s512bh_pkg::*;

	word8_t work_q;
	word_t  t1;
	word_t  t2;
	word_t  ch;
	word_t  maj;

	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + big_sigma1(work_q[4]) + ch + kt + wt;
	assign t2  = big_sigma0(work_q[0]) + maj;
	assign work = work_q;

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			work_q <= init_val;
		end else if (ctrl.step) begin
			work_q <= {work_q[6], work_q[5], work_q[4], work_q[3] + t1,
				work_q[2], work_q[1], work_q[0], t1 + t2};
		end
	end

endmodule

@@ rtl/core/sha512_256_block_hash.sv @@
// Top level of the SHA-512/256 block hash: sequencer, chaining values, output.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata = message_word, s_tlast = last_word
//  m_*     | out | m_tvalid/m_tready | m_tdata = digest_word, word_index; m_tlast = last_result
//  cfg_*   | in  | cfg_we            | cfg_wdata = full_state_output
//
// A word that finishes a block is accepted, then runs 80 rounds on the shared round unit
// (ST_ROUND) and one chaining add (ST_ADD). A last word then emits 4 or 8 words, one per
// cycle when m_tready stays high. s_tready is low during the rounds and the chaining add
// after a block-finishing word and, after a last word, until the last output transaction.
// Reset is asynchronous, clears control state and loads the initial vector into the
// chaining values.
module sha512_256_block_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] message_word
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] digest_word, [66:64] word_index, [71:67] zero
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import s512bh_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_ADD   = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	localparam rnd_t LAST_ROUND = RND_W'(ROUNDS - 1);
	localparam logic [CNT_W-1:0] LAST_WORD_IDX = CNT_W'(BLOCK_WORDS - 1);
	localparam logic [2:0] LAST_IDX_FULL = 3'd7;
	localparam logic [2:0] LAST_IDX_DIGEST = 3'd3;

	state_t           state_q;
	rnd_t             rnd_q;
	logic [CNT_W-1:0] wcnt_q;
	logic             pend_q;
	logic             full_q;
	logic [2:0]       idx_q;
	word8_t           cv_q;
	word8_t           work;
	word_t            wt;
	logic             s_acc;
	logic             m_acc;
	logic             out_last;
	sched_ctrl_t      sched_ctrl;
	round_ctrl_t      round_ctrl;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_acc    = m_tvalid && m_tready;
	assign out_last = (idx_q == (full_q ? LAST_IDX_FULL : LAST_IDX_DIGEST));
	assign m_tlast  = out_last;
	assign m_tdata  = {5'd0, idx_q, cv_q[idx_q]};

	assign sched_ctrl.load = s_acc;
	assign sched_ctrl.step = (state_q == ST_ROUND);
	assign round_ctrl.init = s_acc && (wcnt_q == LAST_WORD_IDX);
	assign round_ctrl.step = (state_q == ST_ROUND);

	s512bh_sched u_sched (
		.clk     (clk),
		.ctrl    (sched_ctrl),
		.word_in (s_tdata),
		.wt      (wt)
	);

	s512bh_round u_round (
		.clk      (clk),
		.ctrl     (round_ctrl),
		.init_val (cv_q),
		.kt       (round_k(rnd_q)),
		.wt       (wt),
		.work     (work)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (cfg_we) begin
			full_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			wcnt_q  <= '0;
			pend_q  <= 1'b0;
			idx_q   <= '0;
			cv_q    <= INIT_VECTOR;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						pend_q <= s_tlast;
						if (wcnt_q == LAST_WORD_IDX) begin
							wcnt_q  <= '0;
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (s_tlast) begin
							wcnt_q  <= '0;
							state_q <= ST_EMIT;
						end else begin
							wcnt_q <= wcnt_q + 1'b1;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						cv_q[i] <= cv_q[i] + work[i];
					end
					state_q <= pend_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (m_acc) begin
						if (out_last) begin
							idx_q   <= '0;
							cv_q    <= INIT_VECTOR;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_emit_while_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while output run in progress");

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= LAST_ROUND))
		else $error("round counter out of range");

	a_partial_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tlast && (wcnt_q != LAST_WORD_IDX)) |=> (state_q == ST_EMIT))
		else $error("last word of partial block did not start output");

	a_tlast_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (idx_q == LAST_IDX_FULL || idx_q == LAST_IDX_DIGEST))
		else $error("tlast on unexpected word index");

endmodule

@@ verif/tb_sha512_256_block_hash.sv @@
// Self-checking stream testbench for the SHA-512/256 block hash with its own hash model.
`timescale 1ns / 1ps

module tb_sha512_256_block_hash;

	import s512bh_pkg::word_t;

	localparam int CLK_PERIOD = 12;
	localparam int DRAIN_GAP = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_WORDS = 200;
	localparam int DIR_ROWS = 21;

	localparam word_t SHA_IV [8] = '{
		64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2, 64'h2393B86B6F53B151, 64'h963877195940EABD,
		64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992, 64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
	};

	localparam word_t ROUND_K [80] = '{
		64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
		64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
		64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
		64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
		64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
		64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
		64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
		64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
		64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
		64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
		64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
		64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
		64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
		64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
		64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
		64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
		64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
		64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
		64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
		64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
	};

	typedef struct {
		word_t word;
		logic [2:0] idx;
		logic last;
	} digest_item_t;

	typedef struct packed {
		word_t word;
		logic last;
		logic typed_iv;
		logic set_cfg;
		logic cfg_val;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [71:0] m_tdata;
	logic m_tlast;
	logic cfg_we;
	logic cfg_wdata;

	word_t chain [8];
	word_t sched_words [16];
	logic [3:0] blk_pos;
	logic full_mode;

	digest_item_t pending_digest_q [$];
	int unsigned words_sent;
	int unsigned results_queued;
	int unsigned mismatch_count;
	int unsigned send_idle_pct;
	int unsigned rcv_idle_pct;
	int unsigned hold_requests;
	int unsigned hold_served;
	int unsigned hold_left;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
		'{64'h0000000000000000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h8000000000000000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h0000000000000001, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'hAAAAAAAAAAAAAAAA, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h5555555555555555, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'hFFFFFFFF00000000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h00000000FFFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h0000000000000000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h0123456789ABCDEF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'hFEDCBA9876543210, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h0000000000000000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h8000000000000001, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h7FFFFFFFFFFFFFFE, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0},
		'{64'h0000000000000000, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'h0000000000000000, 1'b1, 1'b1, 1'b0, 1'b0},
		'{64'h0000000000000000, 1'b1, 1'b1, 1'b1, 1'b1}
	};

	sha512_256_block_hash uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	function automatic word_t ror64(input word_t x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic void sha512_compress();
		word_t w [16];
		word_t r [8];
		word_t m2, m15, wt, t1, t2;
		int t;
		int i;
		w = sched_words;
		r = chain;
		for (t = 0; t < 80; t++) begin
			if (t < 16) begin
				wt = w[t];
			end else begin
				m2 = w[(t - 2) & 15];
				m15 = w[(t - 15) & 15];
				wt = (ror64(m2, 19) ^ ror64(m2, 61) ^ (m2 >> 6)) + w[(t - 7) & 15]
					+ (ror64(m15, 1) ^ ror64(m15, 8) ^ (m15 >> 7)) + w[t & 15];
				w[t & 15] = wt;
			end
			t1 = r[7] + (ror64(r[4], 14) ^ ror64(r[4], 18) ^ ror64(r[4], 41))
				+ ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[t] + wt;
			t2 = (ror64(r[0], 28) ^ ror64(r[0], 34) ^ ror64(r[0], 39))
				+ ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
			r[7] = r[6];
			r[6] = r[5];
			r[5] = r[4];
			r[4] = r[3] + t1;
			r[3] = r[2];
			r[2] = r[1];
			r[1] = r[0];
			r[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			chain[i] = chain[i] + r[i];
	endfunction

	function automatic int absorb_word(input word_t w, input logic l, output digest_item_t res [8]);
		int n;
		int k;
		sched_words[blk_pos] = w;
		blk_pos = blk_pos + 4'd1;
		if (blk_pos == 4'd0)
			sha512_compress();
		if (!l)
			return 0;
		n = full_mode ? 8 : 4;
		for (k = 0; k < n; k++)
			res[k] = '{chain[k], 3'(k), (k == n - 1)};
		chain = SHA_IV;
		blk_pos = 4'd0;
		return n;
	endfunction

	task automatic send_word(input word_t w, input logic l, input logic typed_iv);
		digest_item_t res [8];
		int n;
		int k;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tlast <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n = absorb_word(w, l, res);
		for (k = 0; k < n; k++) begin
			if (typed_iv)
				pending_digest_q.push_back('{SHA_IV[k], 3'(k), (k == n - 1)});
			else
				pending_digest_q.push_back(res[k]);
		end
		results_queued += n;
		words_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		full_mode = v;
	endtask

	task automatic send_message();
		int unsigned kind;
		int unsigned n_words;
		int unsigned i;
		int unsigned pick;
		word_t w;
		kind = $urandom_range(99);
		if (kind < 55)
			n_words = 16;
		else if (kind < 80)
			n_words = 32;
		else if (kind < 88)
			n_words = 48;
		else begin
			n_words = $urandom_range(31, 1);
			if (n_words == 16)
				n_words = 17;
		end
		for (i = 0; i < n_words; i++) begin
			pick = $urandom_range(99);
			if (pick < 8)
				w = '0;
			else if (pick < 16)
				w = '1;
			else
				w = {$urandom, $urandom};
			send_word(w, (i == n_words - 1), 1'b0);
		end
	endtask

	task automatic check_digest_word();
		digest_item_t exp_item;
		if (pending_digest_q.size() == 0) begin
			if (mismatch_count < 10)
				$display("[%0t] unexpected result: word=%h idx=%0d last=%b",
					$realtime, m_tdata[63:0], m_tdata[66:64], m_tlast);
			mismatch_count++;
		end else begin
			exp_item = pending_digest_q.pop_front();
			if (m_tdata[63:0] !== exp_item.word || m_tdata[66:64] !== exp_item.idx
				|| m_tlast !== exp_item.last) begin
				if (mismatch_count < 10)
					$display("[%0t] mismatch: exp word=%h idx=%0d last=%b, got word=%h idx=%0d last=%b",
						$realtime, exp_item.word, exp_item.idx, exp_item.last,
						m_tdata[63:0], m_tdata[66:64], m_tlast);
				mismatch_count++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * 300000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		m_tready <= 1'b0;
		hold_served = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				check_digest_word();
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	initial begin
		int unsigned base_words;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		chain = SHA_IV;
		foreach (sched_words[i])
			sched_words[i] = '0;
		blk_pos = 4'd0;
		full_mode = 1'b0;
		words_sent = 0;
		results_queued = 0;
		mismatch_count = 0;
		hold_requests = 0;
		send_idle_pct = 10;
		rcv_idle_pct = 59;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_cfg) begin
				settle();
				write_mode(dir_rows[i].cfg_val);
			end
			send_word(dir_rows[i].word, dir_rows[i].last, dir_rows[i].typed_iv);
		end

		base_words = words_sent;

		settle();
		write_mode(1'b0);
		while (words_sent - base_words < RANDOM_WORDS / 3)
			send_message();

		settle();
		write_mode(1'b1);
		send_idle_pct = 59;
		rcv_idle_pct = 10;
		while (words_sent - base_words < 2 * RANDOM_WORDS / 3)
			send_message();

		send_idle_pct = 0;
		rcv_idle_pct = 0;
		// stall the output side while the sender keeps offering words
		hold_requests++;
		send_message();
		send_message();
		while (words_sent - base_words < RANDOM_WORDS) begin
			settle();
			write_mode(!full_mode);
			send_message();
		end

		settle();
		if (mismatch_count == 0 && pending_digest_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/s512bh_pkg.sv
rtl/core/s512bh_sched.sv
rtl/core/s512bh_round.sv
rtl/core/sha512_256_block_hash.sv
verif/tb_sha512_256_block_hash.sv
